// File: rtl/dhd_pkg.sv
// ----------------------------------------------------------------------------
// dhd_pkg
// Shared types and constants of the datagram header deframer.
// ----------------------------------------------------------------------------
package dhd_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MULTI_ID    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DETAILS_ID  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_ELEM    = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_LIM = 8'd3;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_MULTI   = 2'd1;
    localparam logic [1:0] KIND_DETAILS = 2'd2;
    localparam logic [1:0] KIND_STATUS  = 2'd3;

    // end status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_SHORT_HDR = 2'd1;
    localparam logic [1:0] STATUS_BAD_ID    = 2'd2;

    typedef struct packed {
        logic [7:0]  multi_element_id;
        logic [7:0]  details_element_id;
        logic [7:0]  max_elements;
        logic [15:0] payload_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [7:0]  payload_byte;
        logic [6:0]  dgram_ref;
        logic        ack_request;
        logic [7:0]  total_parts;
        logic [7:0]  part_number;
        logic [7:0]  details_length;
        logic [15:0] details_crc;
        logic [1:0]  end_status;
        logic [7:0]  element_count;
        logic [15:0] payload_count;
        logic        is_last;
    } result_t;

    // results produced by one request, first then second
    typedef struct packed {
        logic    first_vld;
        logic    second_vld;
        result_t first;
        result_t second;
    } push_t;

endpackage

// File: rtl/dhd_if.sv
// ----------------------------------------------------------------------------
// dhd_if
// Valid/ready channels of the datagram header deframer.
// ----------------------------------------------------------------------------
interface dhd_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, output frame_byte, output frame_end, input ready);
    modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface dhd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  item_kind;
    logic [7:0]  payload_byte;
    logic [6:0]  dgram_ref;
    logic        ack_request;
    logic [7:0]  total_parts;
    logic [7:0]  part_number;
    logic [7:0]  details_length;
    logic [15:0] details_crc;
    logic [1:0]  end_status;
    logic [7:0]  element_count;
    logic [15:0] payload_count;
    logic        is_last;

    modport source (
        output valid, output item_kind, output payload_byte, output dgram_ref,
        output ack_request, output total_parts, output part_number,
        output details_length, output details_crc, output end_status,
        output element_count, output payload_count, output is_last,
        input ready
    );
    modport sink (
        input valid, input item_kind, input payload_byte, input dgram_ref,
        input ack_request, input total_parts, input part_number,
        input details_length, input details_crc, input end_status,
        input element_count, input payload_count, input is_last,
        output ready
    );
endinterface

interface dhd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [dhd_pkg::CFG_INDEX_W-1:0]  index;
    logic [dhd_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/dhd_parse.sv
// ----------------------------------------------------------------------------
// dhd_parse
// Per-byte header parser: updates the frame state on each accepted byte and
// forms up to two results (decoded element or payload byte, then status).
// ----------------------------------------------------------------------------
module dhd_parse (
    input  logic            clk,
    input  logic            rst_n,
    input  dhd_pkg::cfg_t   cfg,
    input  logic            take,
    input  logic [7:0]      frame_byte,
    input  logic            frame_end,
    output dhd_pkg::push_t  push
);

    localparam logic [2:0] PH_HLEN    = 3'd0;
    localparam logic [2:0] PH_ID      = 3'd1;
    localparam logic [2:0] PH_LEN     = 3'd2;
    localparam logic [2:0] PH_DATA    = 3'd3;
    localparam logic [2:0] PH_SKIP    = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_ERROR   = 3'd6;

    localparam logic [1:0] TYPE_NONE    = 2'd0;
    localparam logic [1:0] TYPE_MULTI   = 2'd1;
    localparam logic [1:0] TYPE_DETAILS = 2'd2;

    logic [2:0]  phase_reg,    phase_next;
    logic [7:0]  hdr_left_reg, hdr_left_next;
    logic [1:0]  pos_reg,      pos_next;
    logic [1:0]  etype_reg,    etype_next;
    logic [7:0]  elems_reg,    elems_next;
    logic [7:0]  held_a_reg,   held_a_next;
    logic [7:0]  held_b_reg,   held_b_next;
    logic [15:0] pay_reg,      pay_next;
    logic [1:0]  err_reg,      err_next;

    logic [7:0]  hdr_dec;
    logic        hdr_empty;
    logic [7:0]  elems_inc;

    assign hdr_dec   = hdr_left_reg - 8'd1;
    assign hdr_empty = (hdr_dec == 8'd0);
    assign elems_inc = elems_reg + 8'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        hdr_left_next = hdr_left_reg;
        pos_next      = pos_reg;
        etype_next    = etype_reg;
        elems_next    = elems_reg;
        held_a_next   = held_a_reg;
        held_b_next   = held_b_reg;
        pay_next      = pay_reg;
        err_next      = err_reg;
        push          = '0;

        unique case (phase_reg)
            PH_HLEN:
            begin
                hdr_left_next = frame_byte;
                elems_next    = 8'd0;
                pay_next      = 16'd0;
                err_next      = dhd_pkg::STATUS_OK;
                pos_next      = 2'd0;
                etype_next    = TYPE_NONE;
                if (frame_byte == 8'd0)
                    phase_next = PH_PAYLOAD;
                else if (cfg.max_elements == 8'd0)
                    phase_next = PH_SKIP;
                else
                    phase_next = PH_ID;
            end
            PH_ID:
            begin
                // multi id wins when both ids match
                if (frame_byte == cfg.multi_element_id ||
                    frame_byte == cfg.details_element_id)
                begin
                    etype_next    = (frame_byte == cfg.multi_element_id) ?
                                    TYPE_MULTI : TYPE_DETAILS;
                    hdr_left_next = hdr_dec;
                    phase_next    = hdr_empty ? PH_PAYLOAD : PH_LEN;
                end
                else
                begin
                    etype_next = TYPE_NONE;
                    err_next   = dhd_pkg::STATUS_BAD_ID;
                    phase_next = PH_ERROR;
                end
            end
            PH_LEN:
            begin
                pos_next      = 2'd0;
                hdr_left_next = hdr_dec;
                phase_next    = hdr_empty ? PH_PAYLOAD : PH_DATA;
            end
            PH_DATA:
            begin
                hdr_left_next = hdr_dec;
                if (pos_reg == 2'd0)
                begin
                    held_a_next = frame_byte;
                    pos_next    = 2'd1;
                    if (hdr_empty)
                        phase_next = PH_PAYLOAD;
                end
                else if (pos_reg == 2'd1)
                begin
                    held_b_next = frame_byte;
                    pos_next    = 2'd2;
                    if (hdr_empty)
                        phase_next = PH_PAYLOAD;
                end
                else
                begin
                    push.first_vld = 1'b1;
                    if (etype_reg == TYPE_MULTI)
                    begin
                        push.first.item_kind   = dhd_pkg::KIND_MULTI;
                        push.first.dgram_ref   = held_a_reg[7:1];
                        push.first.ack_request = held_a_reg[0];
                        push.first.total_parts = held_b_reg;
                        push.first.part_number = frame_byte;
                    end
                    else
                    begin
                        push.first.item_kind      = dhd_pkg::KIND_DETAILS;
                        push.first.details_length = held_a_reg;
                        push.first.details_crc    = {frame_byte, held_b_reg};
                    end
                    pos_next   = 2'd0;
                    elems_next = elems_inc;
                    if (hdr_empty)
                        phase_next = PH_PAYLOAD;
                    else if (elems_inc >= cfg.max_elements)
                        phase_next = PH_SKIP;
                    else
                        phase_next = PH_ID;
                end
            end
            PH_SKIP:
            begin
                hdr_left_next = hdr_dec;
                if (hdr_empty)
                    phase_next = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                if (pay_reg < cfg.payload_limit)
                begin
                    push.first_vld          = 1'b1;
                    push.first.item_kind    = dhd_pkg::KIND_PAYLOAD;
                    push.first.payload_byte = frame_byte;
                    pay_next                = pay_reg + 16'd1;
                end
            end
            default:
            begin
                // error phase: swallow bytes until the frame ends
            end
        endcase

        if (frame_end)
        begin
            push.second_vld           = 1'b1;
            push.second.item_kind     = dhd_pkg::KIND_STATUS;
            if (err_next != dhd_pkg::STATUS_OK)
                push.second.end_status = err_next;
            else if (phase_next != PH_PAYLOAD)
                push.second.end_status = dhd_pkg::STATUS_SHORT_HDR;
            else
                push.second.end_status = dhd_pkg::STATUS_OK;
            push.second.element_count = elems_next;
            push.second.payload_count = pay_next;
            push.second.is_last       = 1'b1;
            phase_next    = PH_HLEN;
            hdr_left_next = 8'd0;
            pos_next      = 2'd0;
            etype_next    = TYPE_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HLEN;
            hdr_left_reg <= 8'd0;
            pos_reg      <= 2'd0;
            etype_reg    <= TYPE_NONE;
            elems_reg    <= 8'd0;
            held_a_reg   <= 8'd0;
            held_b_reg   <= 8'd0;
            pay_reg      <= 16'd0;
            err_reg      <= dhd_pkg::STATUS_OK;
        end
        else if (take)
        begin
            phase_reg    <= phase_next;
            hdr_left_reg <= hdr_left_next;
            pos_reg      <= pos_next;
            etype_reg    <= etype_next;
            elems_reg    <= elems_next;
            held_a_reg   <= held_a_next;
            held_b_reg   <= held_b_next;
            pay_reg      <= pay_next;
            err_reg      <= err_next;
        end
    end

endmodule

// File: rtl/dhd_fifo.sv
// ----------------------------------------------------------------------------
// dhd_fifo
// Four-entry result queue that takes up to two results per cycle and hands
// out one per cycle.
// ----------------------------------------------------------------------------
module dhd_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  dhd_pkg::push_t    push,
    input  logic              push_en,
    output logic              room,
    output logic              head_vld,
    output dhd_pkg::result_t  head,
    input  logic              pop
);

    dhd_pkg::result_t mem_reg [4];

    logic [1:0] wptr_reg, wptr_next;
    logic [1:0] rptr_reg, rptr_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] n_push;
    logic       do_pop;
    logic       wr_first, wr_second;
    logic [1:0] wptr_plus1;

    assign room     = (count_reg <= 3'd2);
    assign head_vld = (count_reg != 3'd0);
    assign head     = mem_reg[rptr_reg];
    assign do_pop   = pop && head_vld;

    // compact the pair so that a lone status goes into the first free slot
    assign wr_first   = push_en && (push.first_vld || push.second_vld);
    assign wr_second  = push_en && push.first_vld && push.second_vld;
    assign n_push     = {1'b0, wr_first} + {1'b0, wr_second};
    assign wptr_plus1 = wptr_reg + 2'd1;

    assign wptr_next  = wptr_reg + n_push;
    assign rptr_next  = rptr_reg + {1'b0, do_pop};
    assign count_next = count_reg + {1'b0, n_push} - {2'b00, do_pop};

    always_ff @(posedge clk)
    begin
        if (wr_first)
            mem_reg[wptr_reg] <= push.first_vld ? push.first : push.second;
        if (wr_second)
            mem_reg[wptr_plus1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 2'd0;
            rptr_reg  <= 2'd0;
            count_reg <= 3'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: rtl/datagram_header_deframer_unit.sv
// ----------------------------------------------------------------------------
// datagram_header_deframer_unit
// Splits a byte-serial datagram into decoded header elements, payload bytes
// and an end-of-frame status.
//
// frame:  datagram bytes in, one per request, frame_end on the last byte.
// result: decoded items out; item_kind tells payload byte, multi element,
//         details element or status; is_last marks the status of a frame.
// cfg:    register writes (index 0..3), always ready; other indexes ignored.
// Each byte is parsed in the cycle it is accepted and its results, up to
// two, are registered in a four-entry output queue. One byte is taken every
// cycle while the queue has room for two results; a byte ending a frame can
// add two, so a stalled receiver blocks input once three or more results
// wait. Sustained rate is one byte per cycle whenever results drain at one
// per cycle.
// Reset empties the queue, returns the parser to waiting for a header
// length byte and loads the register defaults (ids 0 and 1, four elements,
// payload limit 255).
// ----------------------------------------------------------------------------
module datagram_header_deframer_unit (
    input  logic          clk,
    input  logic          rst_n,
    dhd_frame_if.sink     frame,
    dhd_result_if.source  result,
    dhd_cfg_if.sink       cfg
);

    dhd_pkg::cfg_t    cfg_reg;
    dhd_pkg::push_t   push;
    dhd_pkg::result_t head;
    logic             room;
    logic             take;

    assign cfg.ready   = 1'b1;
    assign frame.ready = room;
    assign take        = frame.valid && room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.multi_element_id   <= 8'd0;
            cfg_reg.details_element_id <= 8'd1;
            cfg_reg.max_elements       <= 8'd4;
            cfg_reg.payload_limit      <= 16'd255;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == dhd_pkg::REG_MULTI_ID)
                cfg_reg.multi_element_id <= cfg.data[7:0];
            else if (cfg.index == dhd_pkg::REG_DETAILS_ID)
                cfg_reg.details_element_id <= cfg.data[7:0];
            else if (cfg.index == dhd_pkg::REG_MAX_ELEM)
                cfg_reg.max_elements <= cfg.data[7:0];
            else if (cfg.index == dhd_pkg::REG_PAYLOAD_LIM)
                cfg_reg.payload_limit <= cfg.data[15:0];
        end
    end

    dhd_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .take       (take),
        .frame_byte (frame.frame_byte),
        .frame_end  (frame.frame_end),
        .push       (push)
    );

    dhd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_en  (take),
        .room     (room),
        .head_vld (result.valid),
        .head     (head),
        .pop      (result.ready)
    );

    assign result.item_kind      = head.item_kind;
    assign result.payload_byte   = head.payload_byte;
    assign result.dgram_ref      = head.dgram_ref;
    assign result.ack_request    = head.ack_request;
    assign result.total_parts    = head.total_parts;
    assign result.part_number    = head.part_number;
    assign result.details_length = head.details_length;
    assign result.details_crc    = head.details_crc;
    assign result.end_status     = head.end_status;
    assign result.element_count  = head.element_count;
    assign result.payload_count  = head.payload_count;
    assign result.is_last        = head.is_last;

endmodule
